// ----- rtl/core/dotted_oid_text_parser_macros.svh -----
// Assertion macros for the dotted OID text parser.
`ifndef DOTTED_OID_TEXT_PARSER_MACROS_SVH
`define DOTTED_OID_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define DOTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define DOTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dotp_pkg.sv -----
// Types, constants and widths shared by the dotted OID text parser.
package dotp_pkg;

    localparam int MAX_COMPONENTS = 64;
    localparam int ARC_W          = $clog2(MAX_COMPONENTS);
    localparam int VALUE_W        = 32;
    localparam int IDX_W          = 6;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        CLS_DIGIT,
        CLS_DOT,
        CLS_OTHER,
        CLS_END
    } char_class_t;

    // One classified character as it travels from front to back.
    typedef struct packed {
        char_class_t        cls;
        logic [DIGIT_W-1:0] digit;
    } item_t;

endpackage

// ----- rtl/core/dotp_if.sv -----
// Valid/ready channel interfaces for characters in and arcs out.
interface dotp_in_if
    import dotp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

interface dotp_out_if
    import dotp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] component_value;
    logic [IDX_W-1:0]   component_index;
    logic               last_component;
    logic               parse_error;

    modport source (output valid, output component_value, output component_index,
                    output last_component, output parse_error, input ready);
    modport sink   (input valid, input component_value, input component_index,
                    input last_component, input parse_error, output ready);
endinterface

// ----- rtl/core/dotted_oid_text_parser.sv -----
// Top level of the dotted OID text parser: front, queue and back.
//
//  channel | dir | payload                                         | handshake
//  --------+-----+-------------------------------------------------+-----------
//  chars   | in  | char_code[7:0], end_marker                      | valid/ready
//  arcs    | out | component_value[31:0], component_index[5:0],    | valid/ready
//          |     | last_component, parse_error                     |
//
// One character per cycle sustained while the output is not stalled. A character
// passes the queue entry register, then the output register, on its way to an arc.
// rst_n is asynchronous; after reset the parser waits for a new string.
// A stalled output holds the result; the two-entry queue lets the front
// keep taking characters until it fills.
`include "dotted_oid_text_parser_macros.svh"

module dotted_oid_text_parser
    import dotp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dotp_in_if.sink    chars,
    dotp_out_if.source arcs
);

    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    dotp_front u_front (
        .chars      (chars),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    dotp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    dotp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .arcs      (arcs)
    );

    `DOTP_ASSERT_NOW(a_err_format, arcs.valid && arcs.parse_error, arcs.component_value == '0 && arcs.component_index == '0 && arcs.last_component, "error result not zero/last")
    `DOTP_ASSERT_NOW(a_full_has_data, !chars.ready, pop_valid, "queue refuses input while empty")

endmodule

// ----- rtl/core/dotp_front.sv -----
// Front end: takes characters and classifies them into queue items.
module dotp_front
    import dotp_pkg::*;
(
    dotp_in_if.sink     chars,
    output logic        push_valid,
    output item_t       push_item,
    input  logic        push_ready
);

    always_comb
    begin
        push_item.digit = DIGIT_W'(chars.char_code - CH_ZERO);
        if (chars.end_marker)
        begin
            push_item.cls = CLS_END;
        end
        else if (chars.char_code >= CH_ZERO && chars.char_code <= CH_NINE)
        begin
            push_item.cls = CLS_DIGIT;
        end
        else if (chars.char_code == CH_DOT)
        begin
            push_item.cls = CLS_DOT;
        end
        else
        begin
            push_item.cls = CLS_OTHER;
        end
    end

    assign push_valid  = chars.valid;
    assign chars.ready = push_ready;

endmodule

// ----- rtl/core/dotp_queue.sv -----
// Short FIFO of classified items between front and back.
module dotp_queue
    import dotp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  push_ready,
    output logic  pop_valid,
    output item_t pop_item,
    input  logic  pop_ready
);

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/dotp_back.sv -----
// Back end: arc accumulation, error tracking and the output register.
module dotp_back
    import dotp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    input  item_t       pop_item,
    output logic        pop_ready,
    dotp_out_if.source  arcs
);

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [ARC_W-1:0]   arc_reg, arc_next;
    logic               start_reg, start_next;
    logic               pdot_reg, pdot_next;
    logic               err_reg, err_next;

    logic               ovalid_reg, ovalid_next;
    logic [VALUE_W-1:0] ovalue_reg, ovalue_next;
    logic [IDX_W-1:0]   oindex_reg, oindex_next;
    logic               olast_reg, olast_next;
    logic               oerr_reg, oerr_next;

    logic               pop, emit;
    logic [IDX_W-1:0]   arc_idx;

    assign pop_ready = !ovalid_reg || arcs.ready;
    assign pop       = pop_valid && pop_ready;
    // index wraps to IDX_W bits when the arc limit is above 64
    assign arc_idx   = IDX_W'({{IDX_W{1'b0}}, arc_reg});

    always_comb
    begin
        acc_next    = acc_reg;
        arc_next    = arc_reg;
        start_next  = start_reg;
        pdot_next   = pdot_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        ovalue_next = '0;
        oindex_next = '0;
        olast_next  = 1'b1;
        oerr_next   = 1'b1;
        if (pop)
        begin
            case (pop_item.cls)
                CLS_END:
                begin
                    if (!err_reg)
                    begin
                        emit = 1'b1;
                        if (!(start_reg || pdot_reg))
                        begin
                            ovalue_next = acc_reg;
                            oindex_next = arc_idx;
                            oerr_next   = 1'b0;
                        end
                    end
                    acc_next   = '0;
                    arc_next   = '0;
                    start_next = 1'b1;
                    pdot_next  = 1'b0;
                    err_next   = 1'b0;
                end
                CLS_DIGIT:
                begin
                    if (!err_reg)
                    begin
                        // x*10 as x*8 + x*2
                        acc_next   = (acc_reg << 3) + (acc_reg << 1)
                                   + VALUE_W'(pop_item.digit);
                        start_next = 1'b0;
                        pdot_next  = 1'b0;
                    end
                end
                CLS_DOT:
                begin
                    if (!err_reg)
                    begin
                        if (start_reg)
                        begin
                            start_next = 1'b0;
                            pdot_next  = 1'b1;
                        end
                        else if (arc_reg == ARC_W'(MAX_COMPONENTS - 1))
                        begin
                            err_next = 1'b1;
                            emit     = 1'b1;
                        end
                        else
                        begin
                            emit        = 1'b1;
                            ovalue_next = acc_reg;
                            oindex_next = arc_idx;
                            olast_next  = 1'b0;
                            oerr_next   = 1'b0;
                            arc_next    = arc_reg + 1'b1;
                            acc_next    = '0;
                            pdot_next   = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (!err_reg)
                    begin
                        err_next = 1'b1;
                        emit     = 1'b1;
                    end
                end
            endcase
        end

        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (arcs.ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            arc_reg    <= '0;
            start_reg  <= 1'b1;
            pdot_reg   <= 1'b0;
            err_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            arc_reg    <= arc_next;
            start_reg  <= start_next;
            pdot_reg   <= pdot_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ovalue_reg <= ovalue_next;
            oindex_reg <= oindex_next;
            olast_reg  <= olast_next;
            oerr_reg   <= oerr_next;
        end
    end

    assign arcs.valid           = ovalid_reg;
    assign arcs.component_value = ovalue_reg;
    assign arcs.component_index = oindex_reg;
    assign arcs.last_component  = olast_reg;
    assign arcs.parse_error     = oerr_reg;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the dotted OID text parser: random strings, idling and backpressure.
`timescale 1ns / 100ps

module tb;
    import dotp_pkg::*;

    localparam int PHASE_CHARS    = 400;
    localparam int HOLD_CYCLES    = 80;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } char_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   index;
        logic               last;
        logic               bad;
    } arc_t;

    localparam arc_t REJECT = '{value: '0, index: '0, last: 1'b1, bad: 1'b1};

    logic clk = 1'b0;
    logic rst_n;

    dotp_in_if  chars_if ();
    dotp_out_if arcs_if ();

    dotted_oid_text_parser DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .arcs  (arcs_if)
    );

    always #1 clk = ~clk;

    char_item_t chars_to_send[$];
    arc_t       arcs_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;

    int n_strings    = 0;
    int n_chars      = 0;
    int n_arcs_ok    = 0;
    int n_rejects    = 0;
    int n_limit_hits = 0;

    logic char_taken = 1'b0;

    // Parser state mirror
    logic [VALUE_W-1:0] acc;
    logic [6:0]         arc_cnt;
    logic               at_start;
    logic               after_dot;
    logic               bad_seen;

    task automatic clear_parse();
        acc       = '0;
        arc_cnt   = '0;
        at_start  = 1'b1;
        after_dot = 1'b0;
        bad_seen  = 1'b0;
    endtask

    task automatic reject_string();
        bad_seen = 1'b1;
        arcs_due.push_back(REJECT);
        n_rejects++;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic fin);
        arc_t r;
        if (fin) begin
            n_strings++;
            if (!bad_seen) begin
                if (at_start || after_dot) begin
                    arcs_due.push_back(REJECT);
                    n_rejects++;
                end
                else begin
                    r = '{value: acc, index: arc_cnt[IDX_W-1:0], last: 1'b1, bad: 1'b0};
                    arcs_due.push_back(r);
                    n_arcs_ok++;
                end
            end
            clear_parse();
        end
        else if (!bad_seen) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                acc       = acc * 32'd10 + VALUE_W'(ch - CH_ZERO);
                at_start  = 1'b0;
                after_dot = 1'b0;
            end
            else if (ch == CH_DOT) begin
                if (at_start) begin
                    // a leading dot is dropped
                    at_start  = 1'b0;
                    after_dot = 1'b1;
                end
                else if (int'(arc_cnt) + 1 >= MAX_COMPONENTS) begin
                    n_limit_hits++;
                    reject_string();
                end
                else begin
                    r = '{value: acc, index: arc_cnt[IDX_W-1:0], last: 1'b0, bad: 1'b0};
                    arcs_due.push_back(r);
                    n_arcs_ok++;
                    arc_cnt   = arc_cnt + 7'd1;
                    acc       = '0;
                    after_dot = 1'b1;
                end
            end
            else begin
                reject_string();
            end
        end
    endtask

    task automatic add_item(input logic [CHAR_W-1:0] ch, input logic fin);
        char_item_t it;
        it.code = ch;
        it.fin  = fin;
        chars_to_send.push_back(it);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], 1'b0);
        add_item(CHAR_W'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [CHAR_W-1:0] junk_byte();
        logic [CHAR_W-1:0] b;
        do
            b = CHAR_W'($urandom_range(255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT);
        return b;
    endfunction

    // Mostly well-formed strings with random arcs; the rest broken or noise.
    task automatic queue_random_string(input bit force_long);
        logic [CHAR_W-1:0] text[$];
        int n_arcs;
        int ndig;
        int kind;
        bit long_str;
        long_str = force_long || ($urandom_range(49) == 0);
        n_arcs   = long_str ? $urandom_range(62, 66) : $urandom_range(1, 6);
        kind     = $urandom_range(99);
        for (int a = 0; a < n_arcs; a++) begin
            if (a > 0)
                text.push_back(CH_DOT);
            if (long_str)
                ndig = 1;
            else if ($urandom_range(9) == 0)
                ndig = $urandom_range(10, 12);
            else
                ndig = $urandom_range(1, 3);
            for (int d = 0; d < ndig; d++)
                text.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
        end
        if (kind < 6)
            text.push_front(CH_DOT);
        else if (kind < 10)
            text.push_back(CH_DOT);
        else if (kind < 14)
            text.insert($urandom_range(text.size()), junk_byte());
        else if (kind < 17)
            text.insert($urandom_range(text.size()), CH_DOT);
        else if (kind < 19)
            text.delete();
        else if (kind < 22) begin
            text.delete();
            repeat ($urandom_range(1, 8))
                text.push_back(CHAR_W'($urandom_range(255)));
        end
        foreach (text[i])
            add_item(text[i], 1'b0);
        add_item(CHAR_W'($urandom_range(255)), 1'b1);
    endtask

    task automatic queue_phase(input bit with_long);
        int target;
        target = chars_to_send.size() + PHASE_CHARS;
        if (with_long)
            queue_random_string(1'b1);
        while (chars_to_send.size() < target)
            queue_random_string(1'b0);
    endtask

    // Sender stays quiet until every queued char is taken and every arc seen.
    task automatic drain();
        while (chars_to_send.size() != 0 || chars_if.valid || arcs_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic log_mismatch(input string what, input arc_t want, input arc_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t %s: expected value=%0d index=%0d last=%0b err=%0b, got value=%0d index=%0d last=%0b err=%0b",
                     $realtime, what, want.value, want.index, want.last, want.bad,
                     got.value, got.index, got.last, got.bad);
    endtask

    // Char driver
    always @(negedge clk) begin
        char_item_t it;
        if (!rst_n) begin
            chars_if.valid <= 1'b0;
        end
        else if (!chars_if.valid || char_taken) begin
            if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = chars_to_send.pop_front();
                chars_if.valid      <= 1'b1;
                chars_if.char_code  <= it.code;
                chars_if.end_marker <= it.fin;
            end
            else begin
                chars_if.valid <= 1'b0;
            end
        end
    end

    // Arc receiver, with an occasional long hold-off
    always @(negedge clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            arcs_if.ready <= 1'b0;
        end
        else begin
            arcs_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Input transfer: update the mirror
    always @(posedge clk) begin
        char_taken <= rst_n && chars_if.valid && chars_if.ready;
        if (rst_n && chars_if.valid && chars_if.ready) begin
            n_chars++;
            parse_char(chars_if.char_code, chars_if.end_marker);
        end
    end

    // Output transfer: check against the oldest expected arc
    always @(posedge clk) begin
        arc_t got;
        arc_t want;
        if (rst_n && arcs_if.valid && arcs_if.ready) begin
            got = '{value: arcs_if.component_value, index: arcs_if.component_index,
                    last: arcs_if.last_component, bad: arcs_if.parse_error};
            if (arcs_due.size() == 0) begin
                log_mismatch("unexpected arc", '0, got);
            end
            else begin
                want = arcs_due.pop_front();
                if (got.value !== want.value || got.index !== want.index ||
                    got.last !== want.last || got.bad !== want.bad)
                    log_mismatch("arc mismatch", want, got);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (chars_if.valid && chars_if.ready) || (arcs_if.valid && arcs_if.ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n               = 1'b0;
        chars_if.valid      = 1'b0;
        chars_if.char_code  = '0;
        chars_if.end_marker = 1'b0;
        arcs_if.ready       = 1'b0;
        clear_parse();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty, lone dot, leading dot, trailing dot, junk, byte extremes, double dot
        send_idle_pct = 33;
        recv_idle_pct = 69;
        queue_text("");
        queue_text(".");
        queue_text(".5");
        queue_text("1.2.");
        queue_text("9x.5");
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b1);
        add_item(8'hFF, 1'b0);
        add_item(8'h00, 1'b1);
        queue_text("0..7");
        drain();

        queue_phase(1'b1);
        drain();

        send_idle_pct = 69;
        recv_idle_pct = 33;
        queue_phase(1'b0);
        drain();

        // No idling; receiver blocks long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_phase(1'b1);
        hold_reqs++;
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d strings (%0d chars): %0d arcs, %0d rejects, %0d on arc limit",
                 n_strings, n_chars, n_arcs_ok, n_rejects, n_limit_hits);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && arcs_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
